// ===== design/msec_pkg.sv =====
// ----------------------------------------------------------------------------
// msec_pkg
// Shared types, constants and the instruction decoder of the execute core.
// ----------------------------------------------------------------------------
package msec_pkg;

  // program store size and field widths
  localparam int unsigned PROGRAM_DEPTH = 1024;
  localparam int unsigned PC_W          = 10;
  localparam int unsigned LEN_W         = 11;
  localparam int unsigned TGT_W         = 18;

  localparam logic [LEN_W-1:0] LIMIT_MAX   = LEN_W'(PROGRAM_DEPTH);
  localparam logic [LEN_W-1:0] LIMIT_RESET = LEN_W'(1);

  // commands
  localparam logic CMD_EXEC = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // syscall encoding and fixed registers
  localparam logic [31:0] SYSCALL_WORD   = 32'h0000_000C;
  localparam logic [4:0]  REG_ZERO       = 5'd0;
  localparam logic [4:0]  REG_V0         = 5'd2;
  localparam logic [4:0]  REG_A0         = 5'd4;
  localparam logic [31:0] REQ_PRINT_INT  = 32'd1;
  localparam logic [31:0] REQ_EXIT       = 32'd10;
  localparam logic [31:0] REQ_PRINT_CHAR = 32'd11;

  // primary opcodes
  localparam logic [5:0] OPC_RTYPE   = 6'b000000;
  localparam logic [5:0] OPC_BEQ     = 6'b000100;
  localparam logic [5:0] OPC_BNE     = 6'b000101;
  localparam logic [5:0] OPC_ADDI    = 6'b001000;
  localparam logic [5:0] OPC_SLTI    = 6'b001010;
  localparam logic [5:0] OPC_ANDI    = 6'b001100;
  localparam logic [5:0] OPC_ORI     = 6'b001101;
  localparam logic [5:0] OPC_LUI     = 6'b001111;
  localparam logic [5:0] OPC_SPECIAL2 = 6'b011100;

  // function codes
  localparam logic [5:0] FN_ADD = 6'b100000;
  localparam logic [5:0] FN_SUB = 6'b100010;
  localparam logic [5:0] FN_AND = 6'b100100;
  localparam logic [5:0] FN_OR  = 6'b100101;
  localparam logic [5:0] FN_SLT = 6'b101010;
  localparam logic [5:0] FN_MUL = 6'b000010;

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_AND, OP_OR, OP_SLT, OP_MUL, OP_BEQ, OP_BNE,
    OP_ADDI, OP_SLTI, OP_ANDI, OP_ORI, OP_LUI, OP_SYSCALL, OP_BAD
  } op_t;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_PRINT_INT  = 3'd1,
    EV_PRINT_CHAR = 3'd2,
    EV_EXIT       = 3'd3,
    EV_UNKNOWN    = 3'd4,
    EV_INVALID    = 3'd5
  } ev_kind_t;

  // operands and state handed to the execute unit
  typedef struct packed {
    logic             cmd;
    logic [31:0]      word;
    logic [31:0]      a;
    logic [31:0]      b;
    logic [PC_W-1:0]  pc;
    logic             stop;
    logic [LEN_W-1:0] limit;
  } ex_in_t;

  // result, next state and register write from the execute unit
  typedef struct packed {
    ev_kind_t        kind;
    logic [31:0]     value;
    logic [PC_W-1:0] pc;
    logic            stop;
    logic            we;
    logic [4:0]      waddr;
    logic [31:0]     wdata;
  } ex_out_t;

  function automatic op_t decode_op(input logic [31:0] w);
    logic [5:0] hi;
    logic [5:0] lo;
    op_t        op;
    hi = w[31:26];
    lo = w[5:0];
    op = OP_BAD;
    if (w == SYSCALL_WORD) begin
      op = OP_SYSCALL;
    end else if (hi == OPC_RTYPE) begin
      case (lo)
        FN_ADD:  op = OP_ADD;
        FN_SUB:  op = OP_SUB;
        FN_AND:  op = OP_AND;
        FN_OR:   op = OP_OR;
        FN_SLT:  op = OP_SLT;
        default: op = OP_BAD;
      endcase
    end else if (hi == OPC_SPECIAL2) begin
      op = (lo == FN_MUL) ? OP_MUL : OP_BAD;
    end else begin
      case (hi)
        OPC_BEQ:  op = OP_BEQ;
        OPC_BNE:  op = OP_BNE;
        OPC_ADDI: op = OP_ADDI;
        OPC_SLTI: op = OP_SLTI;
        OPC_ANDI: op = OP_ANDI;
        OPC_ORI:  op = OP_ORI;
        OPC_LUI:  op = OP_LUI;
        default:  op = OP_BAD;
      endcase
    end
    return op;
  endfunction

endpackage

// ===== design/msec_exec.sv =====
// ----------------------------------------------------------------------------
// msec_exec
// Execute unit: decodes one instruction, computes the register write, the
// next pc, the halt decision and the reported event; a read command returns operand a.
// ----------------------------------------------------------------------------
module msec_exec (
  input  msec_pkg::ex_in_t  ex_i,
  output msec_pkg::ex_out_t ex_o
);
  import msec_pkg::*;

  op_t              op;
  logic [4:0]       rs_rt;
  logic [4:0]       rd;
  logic [15:0]      imm;
  logic [31:0]      simm;
  logic [TGT_W-1:0] pc_ext;
  logic [TGT_W-1:0] seq_pc;
  logic [TGT_W-1:0] br_pc;
  logic [TGT_W-1:0] target;
  logic [31:0]      prod;
  logic             lt_ab;
  logic             lt_ai;
  logic             halt_now;
  logic             wr_raw;
  logic             out_of_range;

  // field extraction and shared arithmetic
  assign op     = decode_op(ex_i.word);
  assign rs_rt  = ex_i.word[20:16];
  assign rd     = ex_i.word[15:11];
  assign imm    = ex_i.word[15:0];
  assign simm   = {{16{imm[15]}}, imm};
  assign pc_ext = {{(TGT_W-PC_W){1'b0}}, ex_i.pc};
  assign seq_pc = pc_ext + TGT_W'(1);
  assign br_pc  = pc_ext + {{(TGT_W-16){imm[15]}}, imm};
  assign prod   = 32'(ex_i.a * ex_i.b);
  assign lt_ab  = $signed(ex_i.a) < $signed(ex_i.b);
  assign lt_ai  = $signed(ex_i.a) < $signed(simm);

  // instruction behavior
  always_comb begin
    ex_o     = '0;
    ex_o.kind  = EV_NONE;
    ex_o.pc    = ex_i.pc;
    ex_o.stop  = ex_i.stop;
    ex_o.waddr = rd;
    target   = seq_pc;
    halt_now = 1'b0;
    wr_raw   = 1'b0;
    out_of_range = 1'b0;
    if (ex_i.cmd == CMD_READ) begin
      ex_o.value = ex_i.a;
    end else if (ex_i.stop) begin
      ex_o.stop = 1'b1;
    end else if ({1'b0, ex_i.pc} >= ex_i.limit) begin
      ex_o.stop = 1'b1;
    end else begin
      case (op)
        OP_ADD:  begin wr_raw = 1'b1; ex_o.wdata = ex_i.a + ex_i.b; end
        OP_SUB:  begin wr_raw = 1'b1; ex_o.wdata = ex_i.a - ex_i.b; end
        OP_AND:  begin wr_raw = 1'b1; ex_o.wdata = ex_i.a & ex_i.b; end
        OP_OR:   begin wr_raw = 1'b1; ex_o.wdata = ex_i.a | ex_i.b; end
        OP_SLT:  begin wr_raw = 1'b1; ex_o.wdata = {31'b0, lt_ab}; end
        OP_MUL:  begin wr_raw = 1'b1; ex_o.wdata = prod; end
        OP_BEQ:  begin
          if (ex_i.a == ex_i.b) target = br_pc;
        end
        OP_BNE:  begin
          if (ex_i.a != ex_i.b) target = br_pc;
        end
        OP_ADDI: begin
          wr_raw = 1'b1; ex_o.waddr = rs_rt; ex_o.wdata = ex_i.a + simm;
        end
        OP_SLTI: begin
          wr_raw = 1'b1; ex_o.waddr = rs_rt; ex_o.wdata = {31'b0, lt_ai};
        end
        OP_ANDI: begin
          wr_raw = 1'b1; ex_o.waddr = rs_rt; ex_o.wdata = ex_i.a & simm;
        end
        OP_ORI:  begin
          wr_raw = 1'b1; ex_o.waddr = rs_rt; ex_o.wdata = ex_i.a | simm;
        end
        OP_LUI:  begin
          wr_raw = 1'b1; ex_o.waddr = rs_rt; ex_o.wdata = {imm, 16'b0};
        end
        OP_SYSCALL: begin
          // request in a (v0), argument in b (a0)
          if (ex_i.a == REQ_PRINT_INT) begin
            ex_o.kind = EV_PRINT_INT; ex_o.value = ex_i.b;
          end else if (ex_i.a == REQ_PRINT_CHAR) begin
            ex_o.kind = EV_PRINT_CHAR; ex_o.value = {24'b0, ex_i.b[7:0]};
          end else if (ex_i.a == REQ_EXIT) begin
            ex_o.kind = EV_EXIT; halt_now = 1'b1;
          end else begin
            ex_o.kind = EV_UNKNOWN; ex_o.value = ex_i.a; halt_now = 1'b1;
          end
        end
        default: begin
          ex_o.kind = EV_INVALID;
          halt_now  = 1'b1;
        end
      endcase
      // next pc below zero or at or beyond the program length
      out_of_range = target[TGT_W-1] ||
                     (target[TGT_W-2:0] >= {{(TGT_W-1-LEN_W){1'b0}}, ex_i.limit});
      // halt keeps the pc of the halting instruction
      if (halt_now || out_of_range) begin
        ex_o.stop = 1'b1;
      end else begin
        ex_o.pc = target[PC_W-1:0];
      end
      ex_o.we = wr_raw && (ex_o.waddr != REG_ZERO);
    end
  end

endmodule

// ===== design/mips_subset_execute_core_top.sv =====
// ----------------------------------------------------------------------------
// mips_subset_execute_core_top
// Small MIPS32 subset execute core with a 32-entry register file in memory.
// ----------------------------------------------------------------------------
// The core takes one item per clock and returns exactly one result per item,
// in order. An item passes a read stage (two operands read from the register
// file memory, synchronous read) and an execute stage (decode, execute, write
// back); the result sits in the output register until taken. A register
// written by one item is forwarded to the next, so back-to-back dependent
// instructions run at full rate. Throughput is one item per cycle while
// out_stall is low; a held result stalls the input once the execute stage is
// also full. The register file reads as zero after reset through per-entry
// valid bits, so no clearing pass is needed. program_length must be written
// through cfg_wr_en/cfg_wr_data only while idle; the core does not enforce it.
module mips_subset_execute_core_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [msec_pkg::LEN_W-1:0]    cfg_wr_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_command,
  input  logic [31:0]                   in_instr_word,
  input  logic [4:0]                    in_reg_index,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_event_kind,
  output logic signed [31:0]            out_event_value,
  output logic [msec_pkg::PC_W-1:0]     out_next_pc,
  output logic                          out_halted
);
  import msec_pkg::*;

  // control and architectural state
  logic             s1_v_r;
  logic             out_valid_r;
  logic [PC_W-1:0]  pc_r;
  logic             stop_r;
  logic [LEN_W-1:0] limit_r;
  logic [31:0]      rf_vld_r;
  logic             lw_en_r;

  // stage 1 payload
  logic             s1_cmd_r;
  logic [31:0]      s1_word_r;
  logic [4:0]       ra_r;
  logic [4:0]       rb_r;
  logic [4:0]       lw_addr_r;
  logic [31:0]      lw_data_r;

  // register file memory
  logic [31:0]      rf_mem [32];
  logic [31:0]      rf_qa_r;
  logic [31:0]      rf_qb_r;

  // output register
  logic [2:0]       out_kind_r;
  logic [31:0]      out_value_r;
  logic [PC_W-1:0]  out_pc_r;
  logic             out_halted_r;

  logic             accept;
  logic             s1_adv;
  logic             in_syscall;
  logic [4:0]       ra;
  logic [4:0]       rb;
  logic [31:0]      op_a;
  logic [31:0]      op_b;
  logic             rf_we;
  ex_in_t           ex_in;
  ex_out_t          ex_out;

  // handshake
  assign s1_adv   = s1_v_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_v_r && out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // operand addresses: syscall reads v0/a0, a read command uses its index
  assign in_syscall = (in_command == CMD_EXEC) && (in_instr_word == SYSCALL_WORD);
  assign ra = (in_command == CMD_READ) ? in_reg_index :
              (in_syscall ? REG_V0 : in_instr_word[25:21]);
  assign rb = in_syscall ? REG_A0 : in_instr_word[20:16];

  // register file read and write ports
  always_ff @(posedge clk) begin
    if (accept) begin
      rf_qa_r <= rf_mem[ra];
      rf_qb_r <= rf_mem[rb];
    end
    if (rf_we) begin
      rf_mem[ex_out.waddr] <= ex_out.wdata;
    end
  end

  // forward the latest write, unwritten entries read as zero
  always_comb begin
    if (lw_en_r && (lw_addr_r == ra_r)) begin
      op_a = lw_data_r;
    end else begin
      op_a = rf_vld_r[ra_r] ? rf_qa_r : 32'b0;
    end
    if (lw_en_r && (lw_addr_r == rb_r)) begin
      op_b = lw_data_r;
    end else begin
      op_b = rf_vld_r[rb_r] ? rf_qb_r : 32'b0;
    end
  end

  // execute stage
  assign ex_in = '{cmd: s1_cmd_r, word: s1_word_r, a: op_a, b: op_b,
                   pc: pc_r, stop: stop_r, limit: limit_r};

  msec_exec u_exec (
    .ex_i (ex_in),
    .ex_o (ex_out)
  );

  assign rf_we = s1_adv && ex_out.we;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pc_r        <= '0;
      stop_r      <= 1'b0;
      limit_r     <= LIMIT_RESET;
      rf_vld_r    <= '0;
      lw_en_r     <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        pc_r        <= ex_out.pc;
        stop_r      <= ex_out.stop;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        limit_r <= (cfg_wr_data > LIMIT_MAX) ? LIMIT_MAX : cfg_wr_data;
      end
      if (rf_we) begin
        rf_vld_r[ex_out.waddr] <= 1'b1;
        lw_en_r                <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd_r  <= in_command;
      s1_word_r <= in_instr_word;
      ra_r      <= ra;
      rb_r      <= rb;
    end
    if (rf_we) begin
      lw_addr_r <= ex_out.waddr;
      lw_data_r <= ex_out.wdata;
    end
    if (s1_adv) begin
      out_kind_r   <= ex_out.kind;
      out_value_r  <= ex_out.value;
      out_pc_r     <= ex_out.pc;
      out_halted_r <= ex_out.stop;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_kind  = out_kind_r;
  assign out_event_value = out_value_r;
  assign out_next_pc     = out_pc_r;
  assign out_halted      = out_halted_r;

  // checks
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stop_r |=> stop_r)
    else $error("halt flag cleared");

  a_no_zero_write: assert property (@(posedge clk) disable iff (!rst_n)
    rf_we |-> (ex_out.waddr != REG_ZERO))
    else $error("write to register zero");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && out_valid_r))
    else $error("input stalled with room in the pipe");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv))
    else $error("result appeared without an executed item");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the execute core with directed and random instruction streams and
// checks every result transfer against an in-bench interpreter. The streams
// are built from the interpreter state so that programs keep running. One
// halting cause, chosen at random, ends the run.
// ----------------------------------------------------------------------------
module testbench;
  import msec_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;

  // expected contents of one result transfer
  typedef struct packed {
    ev_kind_t        kind;
    logic [31:0]     value;
    logic [PC_W-1:0] pc;
    logic            halted;
  } exec_result_t;

  typedef enum int {
    HALT_INVALID, HALT_EXIT, HALT_UNKNOWN, HALT_BELOW_ZERO, HALT_PAST_END,
    HALT_LENGTH_LOWERED
  } halt_cause_t;

  logic                   clk           = 1'b0;
  logic                   rst_n         = 1'b0;
  logic                   cfg_wr_en     = 1'b0;
  logic [LEN_W-1:0]       cfg_wr_data   = '0;
  logic                   in_valid      = 1'b0;
  logic                   in_stall;
  logic                   in_command    = CMD_EXEC;
  logic [31:0]            in_instr_word = '0;
  logic [4:0]             in_reg_index  = '0;
  logic                   out_valid;
  logic                   out_stall     = 1'b0;
  logic [2:0]             out_event_kind;
  logic signed [31:0]     out_event_value;
  logic [PC_W-1:0]        out_next_pc;
  logic                   out_halted;

  // interpreter state
  logic [31:0]            gpr [32] = '{default: '0};
  logic [PC_W-1:0]        model_pc   = '0;
  logic                   model_halt = 1'b0;
  logic [LEN_W-1:0]       model_len  = LIMIT_RESET;

  exec_result_t           pending_results [$];
  int unsigned            error_count   = 0;
  int unsigned            quiet_cycles  = 0;
  int unsigned            send_gap_pct  = 0;
  int unsigned            stall_pct     = 0;
  int unsigned            hold_left     = 0;

  mips_subset_execute_core_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_instr_word   (in_instr_word),
    .in_reg_index    (in_reg_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_kind  (out_event_kind),
    .out_event_value (out_event_value),
    .out_next_pc     (out_next_pc),
    .out_halted      (out_halted)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // interpreter
  // ---------------------------------------------------------------------------
  function automatic int unsigned pc_bound();
    return (model_len < PROGRAM_DEPTH) ? int'(model_len) : PROGRAM_DEPTH;
  endfunction

  function automatic op_t classify_word(input logic [31:0] w);
    if (w == SYSCALL_WORD) return OP_SYSCALL;
    case (w[31:26])
      OPC_RTYPE: begin
        case (w[5:0])
          FN_ADD: return OP_ADD;
          FN_SUB: return OP_SUB;
          FN_AND: return OP_AND;
          FN_OR:  return OP_OR;
          FN_SLT: return OP_SLT;
          default: return OP_BAD;
        endcase
      end
      OPC_SPECIAL2: return (w[5:0] == FN_MUL) ? OP_MUL : OP_BAD;
      OPC_BEQ:  return OP_BEQ;
      OPC_BNE:  return OP_BNE;
      OPC_ADDI: return OP_ADDI;
      OPC_SLTI: return OP_SLTI;
      OPC_ANDI: return OP_ANDI;
      OPC_ORI:  return OP_ORI;
      OPC_LUI:  return OP_LUI;
      default:  return OP_BAD;
    endcase
  endfunction

  function automatic void write_gpr(input logic [4:0] idx, input logic [31:0] data);
    if (idx != REG_ZERO) gpr[idx] = data;
  endfunction

  // advance the interpreter by one accepted item and queue its result
  function automatic void interpret_item(input logic cmd, input logic [31:0] word,
                                         input logic [4:0] idx);
    exec_result_t res;
    logic [4:0]   rs, rt, rd;
    logic [31:0]  a, b, simm;
    int           next_pc;
    logic         stop_now;
    res.kind  = EV_NONE;
    res.value = '0;
    stop_now  = 1'b0;
    if (cmd == CMD_READ) begin
      res.value = gpr[idx];
    end else if (model_halt) begin
      // stopped core ignores executes
    end else if (int'(model_pc) >= int'(pc_bound())) begin
      model_halt = 1'b1;
    end else begin
      rs      = word[25:21];
      rt      = word[20:16];
      rd      = word[15:11];
      a       = gpr[rs];
      b       = gpr[rt];
      simm    = {{16{word[15]}}, word[15:0]};
      next_pc = int'(model_pc) + 1;
      case (classify_word(word))
        OP_ADD:  write_gpr(rd, a + b);
        OP_SUB:  write_gpr(rd, a - b);
        OP_AND:  write_gpr(rd, a & b);
        OP_OR:   write_gpr(rd, a | b);
        OP_SLT:  write_gpr(rd, {31'b0, $signed(a) < $signed(b)});
        OP_MUL:  write_gpr(rd, a * b);
        OP_BEQ:  if (a == b) next_pc = int'(model_pc) + int'($signed(word[15:0]));
        OP_BNE:  if (a != b) next_pc = int'(model_pc) + int'($signed(word[15:0]));
        OP_ADDI: write_gpr(rt, a + simm);
        OP_SLTI: write_gpr(rt, {31'b0, $signed(a) < $signed(simm)});
        OP_ANDI: write_gpr(rt, a & simm);
        OP_ORI:  write_gpr(rt, a | simm);
        OP_LUI:  write_gpr(rt, {word[15:0], 16'h0000});
        OP_SYSCALL: begin
          if (gpr[REG_V0] == REQ_PRINT_INT) begin
            res.kind  = EV_PRINT_INT;
            res.value = gpr[REG_A0];
          end else if (gpr[REG_V0] == REQ_PRINT_CHAR) begin
            res.kind  = EV_PRINT_CHAR;
            res.value = {24'h0, gpr[REG_A0][7:0]};
          end else if (gpr[REG_V0] == REQ_EXIT) begin
            res.kind = EV_EXIT;
            stop_now = 1'b1;
          end else begin
            res.kind  = EV_UNKNOWN;
            res.value = gpr[REG_V0];
            stop_now  = 1'b1;
          end
        end
        default: begin
          res.kind = EV_INVALID;
          stop_now = 1'b1;
        end
      endcase
      // a next pc outside the program stops the core in place
      if (!stop_now && (next_pc < 0 || next_pc >= int'(pc_bound()))) stop_now = 1'b1;
      if (stop_now) model_halt = 1'b1;
      else model_pc = next_pc[PC_W-1:0];
    end
    res.pc     = model_pc;
    res.halted = model_halt;
    pending_results.push_back(res);
  endfunction

  // ---------------------------------------------------------------------------
  // instruction builders
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] rtype_word(input logic [5:0] opc, input logic [4:0] rs,
                                             input logic [4:0] rt, input logic [4:0] rd,
                                             input logic [4:0] shamt, input logic [5:0] fn);
    return {opc, rs, rt, rd, shamt, fn};
  endfunction

  function automatic logic [31:0] itype_word(input logic [5:0] opc, input logic [4:0] rs,
                                             input logic [4:0] rt, input logic [15:0] imm);
    return {opc, rs, rt, imm};
  endfunction

  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 7));
  endfunction

  function automatic logic [15:0] pick_imm();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return 16'h8000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // a valid instruction that keeps the program running from the current pc
  function automatic logic [31:0] pick_instruction();
    int          bound, lo, hi, tgt;
    logic [4:0]  rs, rt, rd;
    logic [15:0] off;
    bound = int'(pc_bound());
    rs    = pick_reg();
    rt    = pick_reg();
    rd    = pick_reg();
    lo    = (int'(model_pc) > 8) ? int'(model_pc) - 8 : 0;
    hi    = (int'(model_pc) + 8 < bound) ? int'(model_pc) + 8 : bound - 1;
    tgt   = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, bound - 1))
                                        : int'($urandom_range(lo, hi));
    off   = 16'(tgt - int'(model_pc));
    // in the last slot only a branch that is always taken keeps running
    if (int'(model_pc) + 1 >= bound) return itype_word(OPC_BEQ, rs, rs, off);
    case (op_t'($urandom_range(OP_ADD, OP_SYSCALL)))
      OP_ADD:  return rtype_word(OPC_RTYPE, rs, rt, rd, 5'($urandom), FN_ADD);
      OP_SUB:  return rtype_word(OPC_RTYPE, rs, rt, rd, 5'($urandom), FN_SUB);
      OP_AND:  return rtype_word(OPC_RTYPE, rs, rt, rd, 5'($urandom), FN_AND);
      OP_OR:   return rtype_word(OPC_RTYPE, rs, rt, rd, 5'($urandom), FN_OR);
      OP_SLT:  return rtype_word(OPC_RTYPE, rs, rt, rd, 5'($urandom), FN_SLT);
      OP_MUL:  return rtype_word(OPC_SPECIAL2, rs, rt, rd, 5'($urandom), FN_MUL);
      OP_BEQ:  return itype_word(OPC_BEQ, rs, rt, off);
      OP_BNE:  return itype_word(OPC_BNE, rs, rt, off);
      OP_ADDI: return itype_word(OPC_ADDI, rs, rt, pick_imm());
      OP_SLTI: return itype_word(OPC_SLTI, rs, rt, pick_imm());
      OP_ANDI: return itype_word(OPC_ANDI, rs, rt, pick_imm());
      OP_ORI:  return itype_word(OPC_ORI, rs, rt, pick_imm());
      OP_LUI:  return itype_word(OPC_LUI, rs, rt, pick_imm());
      default: begin
        // syscall only with a print request, otherwise set one up first
        if (gpr[REG_V0] == REQ_PRINT_INT || gpr[REG_V0] == REQ_PRINT_CHAR)
          return SYSCALL_WORD;
        return itype_word(OPC_ADDI, REG_ZERO, REG_V0,
                          $urandom_range(0, 1) ? 16'(REQ_PRINT_INT) : 16'(REQ_PRINT_CHAR));
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic cmd, input logic [31:0] word, input logic [4:0] idx);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid      = 1'b1;
    in_command    = cmd;
    in_instr_word = word;
    in_reg_index  = idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    interpret_item(cmd, word, idx);
  endtask

  task automatic send_random_item();
    if ($urandom_range(0, 99) < 18) send_item(CMD_READ, $urandom, 5'($urandom));
    else send_item(CMD_EXEC, pick_instruction(), 5'($urandom));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] value);
    wait_idle();
    repeat (3) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    model_len   = value;
  endtask

  // branch back to pc 0 so that any new length keeps the pc in range
  task automatic set_length(input logic [LEN_W-1:0] value);
    if (!model_halt && model_pc != '0)
      send_item(CMD_EXEC, itype_word(OPC_BEQ, REG_ZERO, REG_ZERO, 16'(-int'(model_pc))), '0);
    write_length(value);
  endtask

  // ---------------------------------------------------------------------------
  // output side
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall = ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h", $time, field, got, want);
  endtask

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    exec_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer", out_event_value, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_event_kind !== want.kind)
          report_mismatch("event_kind", 32'(out_event_kind), 32'(want.kind));
        if (out_event_value !== want.value)
          report_mismatch("event_value", out_event_value, want.value);
        if (out_next_pc !== want.pc)
          report_mismatch("next_pc", 32'(out_next_pc), 32'(want.pc));
        if (out_halted !== want.halted)
          report_mismatch("halted", 32'(out_halted), 32'(want.halted));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // reset length of one: reads and a self loop at pc 0
  task automatic test_reset_state();
    send_item(CMD_READ, 32'hFFFF_FFFF, 5'd0);
    send_item(CMD_READ, 32'h0, 5'd31);
    send_item(CMD_EXEC, itype_word(OPC_BEQ, REG_ZERO, REG_ZERO, 16'h0000), 5'd31);
  endtask

  task automatic test_alu_ops();
    write_length(LIMIT_MAX);
    send_item(CMD_EXEC, itype_word(OPC_LUI, 5'd31, 5'd1, 16'hFFFF), '0);
    send_item(CMD_EXEC, itype_word(OPC_ORI, 5'd1, 5'd1, 16'h00FF), '0);
    send_item(CMD_EXEC, itype_word(OPC_ADDI, REG_ZERO, 5'd2, 16'h7FFF), '0);
    send_item(CMD_EXEC, itype_word(OPC_ADDI, REG_ZERO, 5'd3, 16'h8000), '0);
    // junk in the shift field is ignored
    send_item(CMD_EXEC, rtype_word(OPC_RTYPE, 5'd1, 5'd2, 5'd4, 5'h1F, FN_ADD), '0);
    send_item(CMD_EXEC, rtype_word(OPC_RTYPE, 5'd3, 5'd2, 5'd5, 5'h00, FN_SUB), '0);
    send_item(CMD_EXEC, rtype_word(OPC_RTYPE, 5'd1, 5'd3, 5'd6, 5'h0A, FN_AND), '0);
    send_item(CMD_EXEC, rtype_word(OPC_RTYPE, 5'd2, 5'd3, 5'd7, 5'h15, FN_OR), '0);
    send_item(CMD_EXEC, rtype_word(OPC_RTYPE, 5'd3, 5'd2, 5'd8, 5'h00, FN_SLT), '0);
    send_item(CMD_EXEC, rtype_word(OPC_SPECIAL2, 5'd1, 5'd3, 5'd9, 5'h00, FN_MUL), '0);
    send_item(CMD_EXEC, itype_word(OPC_SLTI, 5'd3, 5'd10, 16'hFFFF), '0);
    send_item(CMD_EXEC, itype_word(OPC_ANDI, 5'd1, 5'd11, 16'h8000), '0);
    // write to $0 is dropped
    send_item(CMD_EXEC, itype_word(OPC_ORI, 5'd1, REG_ZERO, 16'h1234), '0);
    send_item(CMD_READ, 32'h0, REG_ZERO);
    send_item(CMD_READ, 32'h0, 5'd11);
  endtask

  task automatic test_branches();
    send_item(CMD_EXEC, itype_word(OPC_BEQ, 5'd1, 5'd1, 16'd2), '0);
    send_item(CMD_EXEC, itype_word(OPC_BNE, 5'd1, 5'd1, 16'd5), '0);
    send_item(CMD_EXEC, itype_word(OPC_BNE, 5'd1, 5'd2, 16'hFFFF), '0);
    send_item(CMD_EXEC, itype_word(OPC_BEQ, 5'd2, 5'd3, 16'd3), '0);
  endtask

  task automatic test_syscalls();
    send_item(CMD_EXEC, itype_word(OPC_ADDI, REG_ZERO, REG_V0, 16'(REQ_PRINT_INT)), '0);
    send_item(CMD_EXEC, itype_word(OPC_ADDI, REG_ZERO, REG_A0, 16'h8000), '0);
    send_item(CMD_EXEC, SYSCALL_WORD, '0);
    send_item(CMD_EXEC, itype_word(OPC_ADDI, REG_ZERO, REG_V0, 16'(REQ_PRINT_CHAR)), '0);
    send_item(CMD_EXEC, itype_word(OPC_ORI, REG_A0, REG_A0, 16'h00C1), '0);
    send_item(CMD_EXEC, SYSCALL_WORD, '0);
  endtask

  task automatic test_random_phase(input int unsigned gap, input int unsigned stall,
                                   input logic [LEN_W-1:0] length, input int unsigned count);
    send_gap_pct = gap;
    stall_pct    = stall;
    set_length(length);
    repeat (count) begin
      send_random_item();
      // now and then let everything drain before going on
      if ($urandom_range(0, 49) == 0) wait_idle();
    end
    wait_idle();
  endtask

  // long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    send_gap_pct = 0;
    stall_pct    = 0;
    set_length(LIMIT_MAX);
    hold_left = 64;
    repeat (16) send_random_item();
    wait_idle();
  endtask

  // one halting cause per run, then executes are ignored and reads still work
  task automatic test_halt();
    halt_cause_t cause;
    logic [31:0] word;
    send_gap_pct = 21;
    stall_pct    = 21;
    set_length(LIMIT_MAX);
    cause = halt_cause_t'($urandom_range(HALT_INVALID, HALT_LENGTH_LOWERED));
    case (cause)
      HALT_INVALID: begin
        do word = $urandom; while (classify_word(word) != OP_BAD);
        send_item(CMD_EXEC, word, '0);
      end
      HALT_EXIT: begin
        send_item(CMD_EXEC, itype_word(OPC_ADDI, REG_ZERO, REG_V0, 16'(REQ_EXIT)), '0);
        send_item(CMD_EXEC, SYSCALL_WORD, '0);
      end
      HALT_UNKNOWN: begin
        send_item(CMD_EXEC, itype_word(OPC_LUI, REG_ZERO, REG_V0, 16'($urandom)), '0);
        send_item(CMD_EXEC, itype_word(OPC_ORI, REG_V0, REG_V0, 16'($urandom)), '0);
        send_item(CMD_EXEC, SYSCALL_WORD, '0);
      end
      HALT_BELOW_ZERO: begin
        send_item(CMD_EXEC, itype_word(OPC_BEQ, REG_ZERO, REG_ZERO, 16'hFFFF), '0);
      end
      HALT_PAST_END: begin
        // the write of the last instruction still lands
        write_length(3);
        repeat (3) send_item(CMD_EXEC, itype_word(OPC_ADDI, 5'd5, 5'd5, 16'd1), '0);
      end
      default: begin
        // pc left beyond a lowered length halts without executing
        repeat (4) send_item(CMD_EXEC, itype_word(OPC_ADDI, 5'd5, 5'd5, 16'd1), '0);
        write_length(2);
        send_item(CMD_EXEC, itype_word(OPC_ADDI, 5'd5, 5'd5, 16'd1), '0);
      end
    endcase
    repeat (3) send_item(CMD_EXEC, $urandom, 5'($urandom));
    send_item(CMD_READ, $urandom, 5'd5);
    repeat (6) send_item(CMD_READ, $urandom, 5'($urandom));
    wait_idle();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_alu_ops();
    test_branches();
    test_syscalls();
    test_random_phase(0, 0, LIMIT_MAX, 85);
    test_random_phase(78, 0, {LEN_W{1'b1}}, 85);
    test_random_phase(0, 78, LEN_W'($urandom_range(2, 32)), 85);
    test_backpressure();
    test_random_phase(21, 21, LEN_W'($urandom_range(1, 200)), 85);
    test_halt();

    wait_idle();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results left over", 32'(pending_results.size()), '0);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
